// ===== sv/cspt_pkg.sv =====
// Package for the cone support point block: payload structs, case codes,
// register indexes and the lane record of the rim search. No dependencies.
`default_nettype none
package cspt_pkg;

	localparam int unsigned CFG_W    = 31;
	localparam int unsigned RIM_BITS = 31;

	typedef enum logic [1:0] {
		CASE_APEX   = 2'd0,
		CASE_RIM    = 2'd1,
		CASE_CENTRE = 2'd2
	} case_t;

	typedef enum logic [1:0] {
		CFG_RADIUS = 2'd0,
		CFG_HEIGHT = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} dir_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [1:0]         which_case;
	} point_t;

	// One lane of the bit-by-bit rim search: target (r*|c|)^2, sigma, m^2*sigma, m*sigma, m.
	typedef struct packed {
		logic [127:0]          t;
		logic [63:0]           s;
		logic [127:0]          p;
		logic [95:0]           q;
		logic [RIM_BITS-1:0]   m;
	} lane_t;

	typedef struct packed {
		logic dy_pos;
		logic apex;
		logic sig_nz;
		logic nx;
		logic nz;
		logic zx;
		logic zz;
	} side_t;

endpackage
`default_nettype wire

// ===== sv/cone_support_point.sv =====
// Top level of the cone support point block: pipeline, registers and result select.
// Depends on cspt_pkg, cspt_mul64 and cspt_rim_step.
//
// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   dir_t (dir_x, dir_y, dir_z)
// out       source     out_valid/out_stall point_t (point_x..z, which_case)
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One transaction enters per cycle while the output is not stalled; each result passes
// through the products, the two-stage 64-bit multipliers and then the 31 stages of the
// rim search (one result bit per stage) before it reaches the output register.
// Reset clears the valid bits and sets both registers to 1.0.
// A stalled output freezes the whole pipeline, so in_stall follows out_stall while a
// result is held.
`default_nettype none
module cone_support_point (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire cspt_pkg::dir_t in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output cspt_pkg::point_t    out_data,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [31:0]    cfg_data
);
	import cspt_pkg::*;

	logic [CFG_W-1:0] radius_q, height_q;
	logic en;

	assign cfg_ready = 1'b1;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= CFG_W'(65536);
			height_q <= CFG_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_RADIUS) radius_q <= cfg_data[CFG_W-1:0];
			if (cfg_index == CFG_HEIGHT) height_q <= cfg_data[CFG_W-1:0];
		end
	end

	// Magnitudes and signs of the direction.
	logic [31:0] mx, my, mz;
	side_t side_in;

	always_comb begin
		mx = in_data.dir_x[31] ? (~in_data.dir_x + 32'd1) : in_data.dir_x;
		my = in_data.dir_y[31] ? (~in_data.dir_y + 32'd1) : in_data.dir_y;
		mz = in_data.dir_z[31] ? (~in_data.dir_z + 32'd1) : in_data.dir_z;
		side_in.dy_pos = !in_data.dir_y[31] && (my != 32'd0);
		side_in.apex   = 1'b0;
		side_in.sig_nz = 1'b0;
		side_in.nx     = in_data.dir_x[31];
		side_in.nz     = in_data.dir_z[31];
		side_in.zx     = (mx == 32'd0);
		side_in.zz     = (mz == 32'd0);
	end

	// Valid bits of every stage: ahead of the search, through it and at the output.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_srch [RIM_BITS];
	logic vld_s37;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s37 <= 1'b0;
			for (int k = 0; k < RIM_BITS; k++) vld_srch[k] <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_srch[0] <= vld_s5;
			for (int k = 0; k < RIM_BITS - 1; k++) vld_srch[k+1] <= vld_srch[k];
			vld_s37 <= vld_srch[RIM_BITS-1];
		end
	end

	// Stage 1: the narrow products.
	logic [63:0] mx2_s1, mz2_s1, myh_s1, rcx_s1, rcz_s1, rr_s1;
	side_t side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mx2_s1  <= 64'(mx) * 64'(mx);
			mz2_s1  <= 64'(mz) * 64'(mz);
			myh_s1  <= 64'(my) * 64'(height_q);
			rcx_s1  <= 64'(radius_q) * 64'(mx);
			rcz_s1  <= 64'(radius_q) * 64'(mz);
			rr_s1   <= 64'(radius_q) * 64'(radius_q);
			side_s1 <= side_in;
		end
	end

	// Stage 2: sigma = dx^2 + dz^2 and 2*dy*h.
	logic [63:0] sigma_s2, a2_s2, rcx_s2, rcz_s2, rr_s2;
	side_t side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sigma_s2 <= mx2_s1 + mz2_s1;
			a2_s2    <= {myh_s1[62:0], 1'b0};
			rcx_s2   <= rcx_s1;
			rcz_s2   <= rcz_s1;
			rr_s2    <= rr_s1;
			side_s2  <= side_s1;
		end
	end

	// Stages 3 and 4: the wide products inside the multipliers.
	logic [127:0] lhs_s4, rhs_s4, tx_s4, tz_s4;

	cspt_mul64 u_mul_lhs (.clk(clk), .en(en), .a(a2_s2),    .b(a2_s2), .prod(lhs_s4));
	cspt_mul64 u_mul_rhs (.clk(clk), .en(en), .a(sigma_s2), .b(rr_s2), .prod(rhs_s4));
	cspt_mul64 u_mul_tx  (.clk(clk), .en(en), .a(rcx_s2),   .b(rcx_s2), .prod(tx_s4));
	cspt_mul64 u_mul_tz  (.clk(clk), .en(en), .a(rcz_s2),   .b(rcz_s2), .prod(tz_s4));

	logic [63:0] sigma_s3, sigma_s4;
	side_t side_s3, side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sigma_s3 <= sigma_s2;
			sigma_s4 <= sigma_s3;
			side_s3  <= side_s2;
			side_s4  <= side_s3;
		end
	end

	// Stage 5: apex decision and start of the rim search.
	lane_t lane_x_s5, lane_z_s5;
	side_t side_srch [RIM_BITS+1];
	side_t side_dec;

	always_comb begin
		side_dec        = side_s4;
		side_dec.apex   = side_s4.dy_pos && (lhs_s4 > rhs_s4);
		side_dec.sig_nz = (sigma_s4 != 64'd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_x_s5 <= '{t: tx_s4, s: sigma_s4, p: '0, q: '0, m: '0};
			lane_z_s5 <= '{t: tz_s4, s: sigma_s4, p: '0, q: '0, m: '0};
			side_srch[0] <= side_dec;
			for (int k = 0; k < RIM_BITS; k++) side_srch[k+1] <= side_srch[k];
		end
	end

	// Stages 6 to 36: one bit of each rim coordinate per stage, most significant first.
	lane_t lane_x [RIM_BITS+1];
	lane_t lane_z [RIM_BITS+1];

	assign lane_x[0] = lane_x_s5;
	assign lane_z[0] = lane_z_s5;

	for (genvar k = 0; k < RIM_BITS; k++) begin : g_rim
		cspt_rim_step #(.BIT(RIM_BITS - 1 - k)) u_step_x (
			.clk(clk), .en(en), .lane_in(lane_x[k]), .lane_out(lane_x[k+1]));
		cspt_rim_step #(.BIT(RIM_BITS - 1 - k)) u_step_z (
			.clk(clk), .en(en), .lane_in(lane_z[k]), .lane_out(lane_z[k+1]));
	end

	// Stage 37: the output register, result select and signs.
	side_t       side_f;
	logic [31:0] rim_x, rim_z, neg_h;
	point_t      res_s37;

	always_comb begin
		side_f = side_srch[RIM_BITS];
		rim_x  = side_f.zx ? 32'd0 : (side_f.nx ? (~32'(lane_x[RIM_BITS].m) + 32'd1)
			: 32'(lane_x[RIM_BITS].m));
		rim_z  = side_f.zz ? 32'd0 : (side_f.nz ? (~32'(lane_z[RIM_BITS].m) + 32'd1)
			: 32'(lane_z[RIM_BITS].m));
		neg_h  = ~32'(height_q) + 32'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (side_f.apex) begin
				res_s37 <= '{point_x: '0, point_y: 32'(height_q), point_z: '0,
					which_case: CASE_APEX};
			end else if (side_f.sig_nz) begin
				res_s37 <= '{point_x: rim_x, point_y: neg_h, point_z: rim_z,
					which_case: CASE_RIM};
			end else begin
				res_s37 <= '{point_x: '0, point_y: neg_h, point_z: '0,
					which_case: CASE_CENTRE};
			end
		end
	end

	assign out_valid = vld_s37;
	assign out_data  = res_s37;
endmodule
`default_nettype wire

// ===== sv/cspt_mul64.sv =====
// Two-stage 64 by 64 bit unsigned multiplier built from four 32 by 32 partial products.
// Depends on nothing but the clock enable of the surrounding pipeline.
`default_nettype none
module cspt_mul64 (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [63:0]  a,
	input  wire logic [63:0]  b,
	output logic      [127:0] prod
);
	logic [63:0] p00_s1, p01_s1, p10_s1, p11_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1 <= 64'(a[31:0])  * 64'(b[31:0]);
			p01_s1 <= 64'(a[31:0])  * 64'(b[63:32]);
			p10_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			p11_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod <= {64'd0, p00_s1} + ({64'd0, p01_s1} << 32) + ({64'd0, p10_s1} << 32)
				+ {p11_s1, 64'd0};
		end
	end
endmodule
`default_nettype wire

// ===== sv/cspt_rim_step.sv =====
// One bit of the rim coordinate search: finds the largest m with m^2*sigma <= target.
// Depends on cspt_pkg for the lane record.
`default_nettype none
module cspt_rim_step #(
	parameter int unsigned BIT = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire cspt_pkg::lane_t lane_in,
	output cspt_pkg::lane_t    lane_out
);
	import cspt_pkg::*;

	logic [127:0] cand;
	logic         take;

	// (m + 2^b)^2 s = m^2 s + 2^(b+1) m s + 2^(2b) s
	always_comb begin
		cand = lane_in.p + ({32'd0, lane_in.q} << (BIT + 1)) + ({64'd0, lane_in.s} << (2 * BIT));
		take = (cand <= lane_in.t);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_out.t <= lane_in.t;
			lane_out.s <= lane_in.s;
			lane_out.p <= take ? cand : lane_in.p;
			lane_out.q <= take ? (lane_in.q + ({32'd0, lane_in.s} << BIT)) : lane_in.q;
			lane_out.m <= take ? (lane_in.m | (RIM_BITS'(1) << BIT)) : lane_in.m;
		end
	end
endmodule
`default_nettype wire

// ===== sv/cspt_checker.sv =====
// Port-level checks for the cone support point block, bound to the top level.
// Depends on cspt_pkg for the case codes.
`default_nettype none
module cspt_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire cspt_pkg::dir_t   in_data,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire cspt_pkg::point_t out_data,
	input wire logic             cfg_valid,
	input wire logic             cfg_ready,
	input wire logic [1:0]       cfg_index,
	input wire logic [31:0]      cfg_data
);
	import cspt_pkg::*;

	// The input is held back exactly while a result waits downstream.
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow the output stall");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_case_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.which_case == CASE_APEX || out_data.which_case == CASE_RIM
			|| out_data.which_case == CASE_CENTRE))
		else $error("result carries an unused case code");

	a_apex_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.which_case == CASE_APEX |->
			out_data.point_x == 0 && out_data.point_z == 0 && !out_data.point_y[31])
		else $error("apex result off the axis");
endmodule

bind cone_support_point cspt_checker u_cspt_checker (.*);
`default_nettype wire
